>>> rtl/fwt_pkg.sv
package fwt_pkg;

  localparam int unsigned SlotW      = 6;
  localparam int unsigned ThreadW    = 8;
  localparam int unsigned KeyW       = 64;
  localparam int unsigned LimitW     = 7;
  localparam int unsigned SecW       = 32;
  localparam int unsigned UsecW      = 20;
  localparam int unsigned ProdW      = SecW + UsecW;
  localparam int unsigned DeadlineW  = 64;
  localparam int unsigned UsecPerSec = 1000000;

  typedef enum logic [1:0] {
    OP_WAIT    = 2'd0,
    OP_WAKE    = 2'd1,
    OP_REQUEUE = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [KeyW-1:0]    key;
    logic [ThreadW-1:0] thread;
  } slot_entry_t;

  typedef struct packed {
    logic                 status;
    logic [SlotW-1:0]     slot;
    logic [ThreadW-1:0]   thread;
    logic                 woken;
    logic                 timed;
    logic [DeadlineW-1:0] deadline;
  } result_t;

  typedef struct packed {
    logic                we;
    logic                re;
    slot_entry_t         wdata;
  } ram_ctrl_t;

endpackage

>>> rtl/fwt_slot_ram.sv
module fwt_slot_ram #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                       clk_i,
  input  fwt_pkg::ram_ctrl_t         ctrl_i,
  input  logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  logic [$clog2(DEPTH)-1:0]   raddr_i,
  output fwt_pkg::slot_entry_t       rdata_o
);
  import fwt_pkg::*;

  slot_entry_t mem [DEPTH];
  slot_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.we) begin
      mem[waddr_i] <= ctrl_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.re) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/futex_wait_table.sv
// Futex wait table. Every transaction walks the slot table one slot per cycle, reading
// key and thread from a memory with a registered read while the valid bits sit in
// flip-flops. An item is accepted, scans up to SLOTS slots (a wait stops at the lowest
// free slot) and then posts its final result; the block takes no new item until it is
// idle again. The scan pauses whenever a woken result is ready and the output
// register is still stalled. Wake and requeue report each woken thread as its own
// result, with last set on the final one; wait, clear and an empty wake report one.
module futex_wait_table #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  op_i,
  input  logic [fwt_pkg::KeyW-1:0]    key_addr_i,
  input  logic [fwt_pkg::ThreadW-1:0] thread_id_i,
  input  logic [fwt_pkg::LimitW-1:0]  wake_limit_i,
  input  logic [fwt_pkg::KeyW-1:0]    new_key_addr_i,
  input  logic                        has_timeout_i,
  input  logic [fwt_pkg::SecW-1:0]    timeout_sec_i,
  input  logic [fwt_pkg::UsecW-1:0]   timeout_usec_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        status_o,
  output logic [fwt_pkg::SlotW-1:0]   slot_index_o,
  output logic [fwt_pkg::ThreadW-1:0] thread_out_o,
  output logic                        woken_valid_o,
  output logic                        timed_o,
  output logic [fwt_pkg::DeadlineW-1:0] deadline_us_o,
  output logic                        last_o
);
  import fwt_pkg::*;

  localparam int unsigned IdxW = $clog2(SLOTS);

  state_e               state_q, state_d;
  logic [SLOTS-1:0]     valid_q, valid_d;
  logic [IdxW-1:0]      idx_q, idx_d;
  logic                 pend_vld_q, pend_vld_d;
  logic                 out_vld_q, out_vld_d;
  logic                 out_last_q, out_last_d;
  result_t              pend_q, pend_d;
  result_t              out_q, out_d;
  op_e                  op_q;
  logic [KeyW-1:0]      key_q;
  logic [KeyW-1:0]      new_key_q;
  logic [ThreadW-1:0]   thr_q;
  logic [LimitW-1:0]    left_q, left_d;
  logic                 has_to_q;
  logic [UsecW-1:0]     usec_q;
  logic [ProdW-1:0]     prod_q;

  ram_ctrl_t            ram_ctrl;
  logic [IdxW-1:0]      ram_raddr;
  slot_entry_t          rd_entry;

  logic                 in_acc;
  logic                 out_free;
  logic                 last_slot;
  logic                 key_hit;
  logic                 thr_hit;
  logic                 wait_hit;
  logic                 wake_hit;
  logic                 move_hit;
  logic                 emit_pend;
  logic                 adv;
  result_t              fin_res;

  fwt_slot_ram #(
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .ctrl_i  (ram_ctrl),
    .waddr_i (idx_q),
    .raddr_i (ram_raddr),
    .rdata_o (rd_entry)
  );

  assign in_acc    = in_valid_i && (state_q == ST_IDLE);
  assign out_free  = !out_vld_q || !out_stall_i;
  assign last_slot = (idx_q == IdxW'(SLOTS - 1));
  assign key_hit   = valid_q[idx_q] && (rd_entry.key == key_q);
  assign thr_hit   = valid_q[idx_q] && (rd_entry.thread == thr_q);
  assign wait_hit  = (op_q == OP_WAIT) && !valid_q[idx_q];
  assign wake_hit  = ((op_q == OP_WAKE) || (op_q == OP_REQUEUE)) && key_hit
                     && (left_q != '0);
  assign move_hit  = (op_q == OP_REQUEUE) && key_hit && (left_q == '0);
  assign emit_pend = wake_hit && pend_vld_q;
  assign adv       = (state_q == ST_SCAN) && !(emit_pend && !out_free);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (adv && (wait_hit || last_slot)) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    fin_res        = '0;
    fin_res.status = (op_q == OP_WAIT);

    ram_ctrl.we    = adv && (wait_hit || move_hit);
    ram_ctrl.re    = in_acc || (adv && !last_slot);
    ram_ctrl.wdata.key    = wait_hit ? key_q : new_key_q;
    ram_ctrl.wdata.thread = wait_hit ? thr_q : rd_entry.thread;
    ram_raddr      = in_acc ? '0 : IdxW'(idx_q + 1'b1);

    valid_d    = valid_q;
    idx_d      = idx_q;
    left_d     = left_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    out_vld_d  = out_vld_q && out_stall_i;
    out_last_d = out_last_q;
    out_d      = out_q;

    if (in_acc) begin
      idx_d      = '0;
      left_d     = wake_limit_i;
      pend_vld_d = 1'b0;
    end

    if (adv) begin
      if (!last_slot) begin
        idx_d = IdxW'(idx_q + 1'b1);
      end
      if (wait_hit) begin
        valid_d[idx_q]  = 1'b1;
        pend_vld_d      = 1'b1;
        pend_d          = '0;
        pend_d.slot     = SlotW'(idx_q);
        pend_d.thread   = thr_q;
        pend_d.timed    = has_to_q;
        pend_d.deadline = has_to_q ? (DeadlineW'(prod_q) + DeadlineW'(usec_q)) : '0;
      end
      if (wake_hit) begin
        valid_d[idx_q] = 1'b0;
        left_d         = left_q - 1'b1;
        pend_vld_d     = 1'b1;
        pend_d         = '0;
        pend_d.slot    = SlotW'(idx_q);
        pend_d.thread  = rd_entry.thread;
        pend_d.woken   = 1'b1;
      end
      if ((op_q == OP_CLEAR) && thr_hit) begin
        valid_d[idx_q] = 1'b0;
      end
      if (emit_pend) begin
        out_vld_d  = 1'b1;
        out_last_d = 1'b0;
        out_d      = pend_q;
      end
    end

    if ((state_q == ST_FINISH) && out_free) begin
      out_vld_d  = 1'b1;
      out_last_d = 1'b1;
      out_d      = pend_vld_q ? pend_q : fin_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      valid_q    <= '0;
      idx_q      <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      valid_q    <= valid_d;
      idx_q      <= idx_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q      <= op_e'(op_i);
      key_q     <= key_addr_i;
      new_key_q <= new_key_addr_i;
      thr_q     <= thread_id_i;
      has_to_q  <= has_timeout_i;
      usec_q    <= timeout_usec_i;
      prod_q    <= ProdW'(ProdW'(timeout_sec_i) * ProdW'(UsecPerSec));
    end
    left_q     <= left_d;
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_vld_q;
  assign status_o      = out_q.status;
  assign slot_index_o  = out_q.slot;
  assign thread_out_o  = out_q.thread;
  assign woken_valid_o = out_q.woken;
  assign timed_o       = out_q.timed;
  assign deadline_us_o = out_q.deadline;
  assign last_o        = out_last_q;

endmodule

>>> tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fwt_pkg::*;

  localparam int unsigned SLOTS        = 16;
  localparam int unsigned LIMIT_CYCLES = 2000000;
  localparam int unsigned TAIL_CYCLES  = 4 * (SLOTS + 2);
  localparam logic [KeyW-1:0] KEY_LO   = '0;
  localparam logic [KeyW-1:0] KEY_HI   = '1;
  localparam logic [KeyW-1:0] KEY_C    = 64'h5A5A_0000_C3C3_FFFF;

  typedef struct packed {
    logic                 status;
    logic [SlotW-1:0]     slot;
    logic [ThreadW-1:0]   thread;
    logic                 woken;
    logic                 timed;
    logic [DeadlineW-1:0] deadline;
    logic                 last;
  } futex_result_t;

  logic                   clk_i          = 1'b0;
  logic                   rst_ni         = 1'b0;
  logic                   in_valid_i     = 1'b0;
  logic                   in_stall_o;
  logic [1:0]             op_i           = OP_WAIT;
  logic [KeyW-1:0]        key_addr_i     = '0;
  logic [ThreadW-1:0]     thread_id_i    = '0;
  logic [LimitW-1:0]      wake_limit_i   = '0;
  logic [KeyW-1:0]        new_key_addr_i = '0;
  logic                   has_timeout_i  = 1'b0;
  logic [SecW-1:0]        timeout_sec_i  = '0;
  logic [UsecW-1:0]       timeout_usec_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i    = 1'b0;
  logic                   status_o;
  logic [SlotW-1:0]       slot_index_o;
  logic [ThreadW-1:0]     thread_out_o;
  logic                   woken_valid_o;
  logic                   timed_o;
  logic [DeadlineW-1:0]   deadline_us_o;
  logic                   last_o;

  futex_wait_table #(
    .SLOTS(SLOTS)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .key_addr_i    (key_addr_i),
    .thread_id_i   (thread_id_i),
    .wake_limit_i  (wake_limit_i),
    .new_key_addr_i(new_key_addr_i),
    .has_timeout_i (has_timeout_i),
    .timeout_sec_i (timeout_sec_i),
    .timeout_usec_i(timeout_usec_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .slot_index_o  (slot_index_o),
    .thread_out_o  (thread_out_o),
    .woken_valid_o (woken_valid_o),
    .timed_o       (timed_o),
    .deadline_us_o (deadline_us_o),
    .last_o        (last_o)
  );

  always #5 clk_i = ~clk_i;

  bit                 tbl_valid [SLOTS];
  logic [KeyW-1:0]    tbl_key   [SLOTS];
  logic [ThreadW-1:0] tbl_thread[SLOTS];

  futex_result_t results_due[$];
  futex_result_t got_r;
  futex_result_t want_r;
  bit            out_taken       = 1'b0;
  int unsigned   mismatches      = 0;
  int unsigned   items_sent      = 0;
  int unsigned   results_checked = 0;
  int unsigned   wakes_seen      = 0;
  int unsigned   full_seen       = 0;
  int unsigned   cycles          = 0;
  bit            send_idle_en    = 1'b1;
  bit            sink_idle_en    = 1'b1;
  int unsigned   stall_run       = 0;
  logic [KeyW-1:0]    key_pool[4];
  logic [ThreadW-1:0] thr_pool[8];

  function automatic futex_result_t blank_result();
    futex_result_t r;
    r = '0;
    return r;
  endfunction

  task automatic wake_slots(input logic [KeyW-1:0] key, input logic [LimitW-1:0] limit);
    futex_result_t batch[$];
    futex_result_t r;
    int unsigned   left;
    left = 32'(limit);
    for (int i = 0; i < SLOTS && left != 0; i++) begin
      if (tbl_valid[i] && tbl_key[i] == key) begin
        tbl_valid[i] = 1'b0;
        r        = blank_result();
        r.slot   = SlotW'(i);
        r.thread = tbl_thread[i];
        r.woken  = 1'b1;
        batch.push_back(r);
        left--;
      end
    end
    if (batch.size() == 0) begin
      r      = blank_result();
      r.last = 1'b1;
      batch.push_back(r);
    end else begin
      batch[batch.size()-1].last = 1'b1;
    end
    foreach (batch[k]) results_due.push_back(batch[k]);
  endtask

  task automatic predict_futex_op(input op_e op, input logic [KeyW-1:0] key,
                                  input logic [ThreadW-1:0] thr,
                                  input logic [LimitW-1:0] limit,
                                  input logic [KeyW-1:0] new_key, input logic has_to,
                                  input logic [SecW-1:0] sec, input logic [UsecW-1:0] usec);
    futex_result_t r;
    bit            placed;
    r      = blank_result();
    placed = 1'b0;
    case (op)
      OP_WAIT: begin
        for (int i = 0; i < SLOTS && !placed; i++) begin
          if (!tbl_valid[i]) begin
            tbl_valid[i]  = 1'b1;
            tbl_key[i]    = key;
            tbl_thread[i] = thr;
            r.slot        = SlotW'(i);
            r.thread      = thr;
            r.timed       = has_to;
            r.deadline    = has_to ? 64'(sec) * 64'(UsecPerSec) + 64'(usec) : '0;
            placed        = 1'b1;
          end
        end
        if (!placed) r.status = 1'b1;
        r.last = 1'b1;
        results_due.push_back(r);
      end
      OP_WAKE: begin
        wake_slots(key, limit);
      end
      OP_REQUEUE: begin
        wake_slots(key, limit);
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_valid[i] && tbl_key[i] == key) tbl_key[i] = new_key;
        end
      end
      default: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_valid[i] && tbl_thread[i] == thr) tbl_valid[i] = 1'b0;
        end
        r.last = 1'b1;
        results_due.push_back(r);
      end
    endcase
  endtask

  // Called at a rising edge; returns at the edge where the transaction is accepted.
  task automatic send_futex_op(input op_e op, input logic [KeyW-1:0] key,
                               input logic [ThreadW-1:0] thr, input logic [LimitW-1:0] limit,
                               input logic [KeyW-1:0] new_key, input logic has_to,
                               input logic [SecW-1:0] sec, input logic [UsecW-1:0] usec);
    int unsigned gap;
    int unsigned r;
    bit          stalled;
    gap = 0;
    if (send_idle_en) begin
      r   = $urandom_range(0, 99);
      gap = (r < 60) ? 0 : (r < 94) ? $urandom_range(1, 3) : $urandom_range(15, 60);
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    op_i           <= op;
    key_addr_i     <= key;
    thread_id_i    <= thr;
    wake_limit_i   <= limit;
    new_key_addr_i <= new_key;
    has_timeout_i  <= has_to;
    timeout_sec_i  <= sec;
    timeout_usec_i <= usec;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    items_sent++;
    predict_futex_op(op, key, thr, limit, new_key, has_to, sec, usec);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [KeyW-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  task automatic test_directed_cases();
    logic [ThreadW-1:0] thr;
    logic               has_to;
    logic [SecW-1:0]    sec;
    logic [UsecW-1:0]   usec;
    send_futex_op(OP_WAKE, KEY_LO, 8'd0, 7'd127, rand_key(), 1'b1, '1, '1);
    send_futex_op(OP_CLEAR, rand_key(), 8'd0, 7'($urandom), rand_key(), 1'b0, $urandom,
                  20'($urandom));
    for (int i = 0; i < SLOTS; i++) begin
      thr    = (i == 0) ? 8'd0 : (i >= 14) ? 8'd255 : 8'(i * 13);
      has_to = (i % 3) != 0;
      sec    = (i == 1) ? '1 : $urandom;
      usec   = (i == 1) ? '1 : (i == 2) ? 20'd999999 : 20'($urandom_range(0, 999999));
      send_futex_op(OP_WAIT, (i % 2 == 0) ? KEY_LO : KEY_HI, thr, 7'($urandom), rand_key(),
                    has_to, sec, usec);
    end
    send_futex_op(OP_WAIT, KEY_C, 8'd77, '0, rand_key(), 1'b1, 32'd5, 20'd5);
    send_futex_op(OP_WAKE, KEY_HI, 8'($urandom), 7'd0, rand_key(), 1'b0, '0, '0);
    send_futex_op(OP_REQUEUE, KEY_HI, 8'($urandom), 7'd0, KEY_C, 1'b0, '0, '0);
    send_futex_op(OP_WAKE, KEY_C, 8'($urandom), 7'd3, rand_key(), 1'b0, '0, '0);
    send_futex_op(OP_REQUEUE, KEY_LO, 8'($urandom), 7'd2, KEY_C, 1'b1, '1, '1);
    send_futex_op(OP_CLEAR, KEY_C, 8'd255, 7'd64, rand_key(), 1'b0, '0, '0);
    send_futex_op(OP_WAKE, KEY_C, 8'($urandom), 7'd127, rand_key(), 1'b0, '0, '0);
    send_futex_op(OP_WAIT, KEY_HI, 8'd1, '0, '0, 1'b0, '1, '1);
    send_futex_op(OP_WAKE, KEY_HI, 8'($urandom), 7'd16, rand_key(), 1'b0, '0, '0);
    drain_results();
  endtask

  task automatic send_random_sequence_op();
    int unsigned        r;
    op_e                op;
    logic [KeyW-1:0]    key;
    logic [KeyW-1:0]    nkey;
    logic [ThreadW-1:0] thr;
    logic [LimitW-1:0]  limit;
    logic [SecW-1:0]    sec;
    logic [UsecW-1:0]   usec;
    r  = $urandom_range(0, 99);
    op = (r < 45) ? OP_WAIT : (r < 65) ? OP_WAKE : (r < 85) ? OP_REQUEUE : OP_CLEAR;
    key   = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, 3)] : rand_key();
    nkey  = ($urandom_range(0, 99) < 80) ? key_pool[$urandom_range(0, 3)] : rand_key();
    thr   = ($urandom_range(0, 99) < 85) ? thr_pool[$urandom_range(0, 7)] : 8'($urandom);
    r     = $urandom_range(0, 99);
    limit = (r < 15) ? 7'd0 : (r < 80) ? 7'($urandom_range(1, 4)) :
            (r < 92) ? 7'(SLOTS) : 7'($urandom_range(17, 127));
    sec   = ($urandom_range(0, 9) == 0) ? 32'($urandom) : 32'($urandom_range(0, 1000));
    usec  = ($urandom_range(0, 9) == 0) ? 20'($urandom_range(999999, 1048575)) :
            20'($urandom_range(0, 999999));
    send_futex_op(op, key, thr, limit, nkey, 1'($urandom), sec, usec);
  endtask

  task automatic test_random_sequences();
    key_pool[0] = KEY_LO;
    key_pool[1] = KEY_HI;
    key_pool[2] = rand_key();
    key_pool[3] = rand_key();
    thr_pool[0] = 8'd0;
    thr_pool[1] = 8'd255;
    for (int i = 2; i < 8; i++) thr_pool[i] = 8'($urandom);
    repeat (170) send_random_sequence_op();
    drain_results();
  endtask

  task automatic test_back_to_back();
    send_idle_en = 1'b0;
    sink_idle_en <= 1'b0;
    repeat (30) send_random_sequence_op();
    drain_results();
    send_idle_en = 1'b1;
    sink_idle_en <= 1'b1;
  endtask

  task automatic test_random_noise();
    repeat (40) begin
      send_futex_op(op_e'($urandom_range(0, 3)), rand_key(), 8'($urandom), 7'($urandom),
                    rand_key(), 1'($urandom), $urandom, 20'($urandom));
    end
  endtask

  always @(posedge clk_i) begin
    if (!sink_idle_en) begin
      out_stall_i <= 1'b0;
      stall_run   <= 0;
    end else if (stall_run == 0) begin
      case ($urandom_range(0, 19))
        0:          begin out_stall_i <= 1'b1; stall_run <= $urandom_range(15, 50); end
        1, 2, 3, 4,
        5, 6, 7:    begin out_stall_i <= 1'b1; stall_run <= $urandom_range(0, 2); end
        default:    begin out_stall_i <= 1'b0; stall_run <= $urandom_range(0, 5); end
      endcase
    end else begin
      stall_run <= stall_run - 1;
    end
  end

  always @(negedge clk_i) begin
    out_taken = rst_ni && out_valid_o && !out_stall_i;
    got_r     = {status_o, slot_index_o, thread_out_o, woken_valid_o, timed_o,
                 deadline_us_o, last_o};
  end

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (out_taken) begin
      if (results_due.size() == 0) begin
        $error("result with nothing pending: slot_index %0d thread_out %0d",
               got_r.slot, got_r.thread);
        mismatches++;
      end else begin
        want_r = results_due.pop_front();
        check_field("status", 64'(want_r.status), 64'(got_r.status));
        check_field("slot_index", 64'(want_r.slot), 64'(got_r.slot));
        check_field("thread_out", 64'(want_r.thread), 64'(got_r.thread));
        check_field("woken_valid", 64'(want_r.woken), 64'(got_r.woken));
        check_field("timed", 64'(want_r.timed), 64'(got_r.timed));
        check_field("deadline_us", want_r.deadline, got_r.deadline);
        check_field("last", 64'(want_r.last), 64'(got_r.last));
        results_checked++;
        if (want_r.woken) wakes_seen++;
        if (want_r.status) full_seen++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               results_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_random_sequences();
    test_back_to_back();
    test_random_noise();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("sent %0d wait/wake/requeue/clear transactions, checked %0d results",
             items_sent, results_checked);
    $display("woken threads %0d, table-full waits %0d, mismatches %0d",
             wakes_seen, full_seen, mismatches);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/fwt_pkg.sv
rtl/fwt_slot_ram.sv
rtl/futex_wait_table.sv
tb/sv/tb_top.sv
